>>> rtl/core/des_pkg.sv
// Shared types and constants of the disk elevator scheduler.
`default_nettype none

package des_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_BITS     = 16;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int MOVE_W       = 22;
  localparam int DSIZE_W      = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CYLINDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CYLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE      = 2'd2;

  localparam logic [DSIZE_W-1:0] CYL_MAX = DSIZE_W'((64'd1 << CYL_BITS) - 64'd1);

  typedef logic [CYL_BITS-1:0] cyl_t;
  typedef logic [MOVE_W-1:0]   move_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    cyl_t cylinder;
    logic batch_end;
  } in_word_t;

  typedef struct packed {
    cyl_t  visit_cylinder;
    move_t running_movement;
    logic  is_disk_end;
    logic  final_res;
  } out_word_t;

  // Schedule settings derived from the configuration registers.
  typedef struct packed {
    cyl_t start_cylinder;
    cyl_t top_cylinder;
    logic top_en;
  } sched_cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_BATCH,
    S_SPLIT,
    S_RD,
    S_CALC,
    S_TOP,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_TOP,
    PH_DOWN
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/core/des_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module des_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/des_seq.sv
// Sequencer: insertion sort into the request RAM, split search and visit emission.
`default_nettype none

module des_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire des_pkg::in_word_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output des_pkg::out_word_t               out_data,
  input  wire des_pkg::sched_cfg_t         cfg,
  output logic                             ram_we,
  output logic [des_pkg::IDX_W-1:0]        ram_waddr,
  output des_pkg::cyl_t                    ram_wdata,
  output logic [des_pkg::IDX_W-1:0]        ram_raddr,
  input  wire des_pkg::cyl_t               ram_rdata
);

  import des_pkg::*;

  state_t    state;
  state_t    state_next;
  phase_t    phase;
  cnt_t      count;
  cnt_t      n;
  cnt_t      idx;
  cnt_t      split;
  cyl_t      v;
  logic      endf;
  cyl_t      head;
  move_t     total;
  out_word_t out_word;

  logic      accept;
  logic      store_ok;
  cnt_t      count_p1;
  cnt_t      count_m1;
  cnt_t      idx_p1;
  cnt_t      idx_m1;
  cnt_t      idx_m2;
  cnt_t      split_m1;
  logic      rd_gt_v;
  logic      rd_gt_head;
  logic      top_hit_rd;
  logic      top_hit_head;
  cyl_t      vis_cyl;
  cyl_t      gap;
  logic [MOVE_W:0] sum;
  move_t     sum_sat;
  logic      final_rd;

  assign accept     = in_valid && in_ready;
  assign store_ok   = count < CNT_W'(MAX_REQUESTS);
  assign count_p1   = count + CNT_W'(1);
  assign count_m1   = count - CNT_W'(1);
  assign idx_p1     = idx + CNT_W'(1);
  assign idx_m1     = idx - CNT_W'(1);
  assign idx_m2     = idx - CNT_W'(2);
  assign split_m1   = split - CNT_W'(1);
  assign rd_gt_v    = ram_rdata > v;
  assign rd_gt_head = ram_rdata > head;
  assign top_hit_rd   = cfg.top_en && (ram_rdata < cfg.top_cylinder);
  assign top_hit_head = cfg.top_en && (head < cfg.top_cylinder);

  // Distance and saturating movement total for the visit being formed.
  assign vis_cyl = (state == S_TOP) ? cfg.top_cylinder : ram_rdata;
  assign gap     = (vis_cyl >= head) ? (vis_cyl - head) : (head - vis_cyl);
  assign sum     = (MOVE_W + 1)'(total) + (MOVE_W + 1)'(gap);
  assign sum_sat = sum[MOVE_W] ? '1 : sum[MOVE_W-1:0];

  // An upward visit is the last only if nothing lies below and no end visit follows.
  assign final_rd = (phase == PH_DOWN) ? (idx == '0)
                  : ((idx_p1 == n) && (split == '0) && !top_hit_rd);

  assign out_valid = (state == S_OUT);
  assign out_data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (store_ok && (count != '0)) begin
            state_next = S_INS;
          end else if (in_data.batch_end) begin
            state_next = S_BATCH;
          end
        end
      end
      S_INS: begin
        if (rd_gt_v) begin
          state_next = (idx == CNT_W'(1)) ? S_PUT : S_INS;
        end else begin
          state_next = endf ? S_BATCH : S_IDLE;
        end
      end
      S_PUT:   state_next = endf ? S_BATCH : S_IDLE;
      S_BATCH: state_next = S_SPLIT;
      S_SPLIT: begin
        if (rd_gt_head) begin
          state_next = S_RD;
        end else if (idx_p1 == n) begin
          state_next = S_TOP;
        end
      end
      S_RD:   state_next = S_CALC;
      S_CALC: state_next = S_OUT;
      S_TOP: begin
        if (top_hit_head) begin
          state_next = S_OUT;
        end else begin
          state_next = (split == '0) ? S_IDLE : S_RD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          unique case (phase)
            PH_UP:   state_next = (idx_p1 < n) ? S_RD : S_TOP;
            PH_TOP:  state_next = (split == '0) ? S_IDLE : S_RD;
            PH_DOWN: state_next = (idx == '0) ? S_IDLE : S_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    ram_wdata = v;
    ram_raddr = idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept && store_ok) begin
          if (count == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_data.cylinder;
          end else begin
            ram_raddr = count_m1[IDX_W-1:0];
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IDX_W-1:0];
        if (rd_gt_v) begin
          // Shift the larger entry up one place and look one further down.
          ram_wdata = ram_rdata;
          ram_raddr = idx_m2[IDX_W-1:0];
        end else begin
          ram_wdata = v;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = v;
      end
      S_BATCH: ram_raddr = '0;
      S_SPLIT: ram_raddr = idx_p1[IDX_W-1:0];
      S_RD:    ram_raddr = idx[IDX_W-1:0];
      S_CALC, S_TOP, S_OUT: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= PH_UP;
      head  <= '0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            v    <= in_data.cylinder;
            endf <= in_data.batch_end;
            idx  <= count;
            if (store_ok && (count == '0)) begin
              if (in_data.batch_end) begin
                n     <= CNT_W'(1);
                count <= '0;
              end else begin
                count <= CNT_W'(1);
              end
            end else if (!store_ok && in_data.batch_end) begin
              // The store is full: the word is dropped but the batch still starts.
              n     <= count;
              count <= '0;
            end
          end
        end
        S_INS, S_PUT: begin
          if ((state == S_INS) && rd_gt_v) begin
            idx <= idx_m1;
          end else if (endf) begin
            n     <= count_p1;
            count <= '0;
          end else begin
            count <= count_p1;
          end
        end
        S_BATCH: begin
          idx   <= '0;
          head  <= cfg.start_cylinder;
          total <= '0;
        end
        S_SPLIT: begin
          if (rd_gt_head) begin
            split <= idx;
            phase <= PH_UP;
          end else if (idx_p1 == n) begin
            split <= n;
          end else begin
            idx <= idx_p1;
          end
        end
        S_CALC: begin
          out_word <= '{visit_cylinder: ram_rdata, running_movement: sum_sat,
                        is_disk_end: 1'b0, final_res: final_rd};
          head     <= ram_rdata;
          total    <= sum_sat;
        end
        S_TOP: begin
          if (top_hit_head) begin
            phase    <= PH_TOP;
            out_word <= '{visit_cylinder: cfg.top_cylinder, running_movement: sum_sat,
                          is_disk_end: 1'b1, final_res: (split == '0)};
            head     <= cfg.top_cylinder;
            total    <= sum_sat;
          end else if (split != '0) begin
            idx   <= split_m1;
            phase <= PH_DOWN;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            case (phase)
              PH_UP: begin
                if (idx_p1 < n) begin
                  idx <= idx_p1;
                end
              end
              PH_TOP: begin
                idx   <= split_m1;
                phase <= PH_DOWN;
              end
              default: begin
                if (idx != '0) begin
                  idx <= idx_m1;
                end
              end
            endcase
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/disk_elevator_scheduler_top.sv
// Top level of the disk elevator scheduler: configuration registers, sequencer and request RAM.
//
// Usage: cylinder requests arrive as words on the in channel (valid/ready); the word
// with batch_end set closes the batch. Each request is placed in sorted position in
// the request RAM as it arrives, written directly into an empty store and otherwise
// with one RAM read and shift per larger stored entry; words beyond MAX_REQUESTS in
// one batch are dropped. After the closing word the block scans the sorted RAM for
// the first request above the start cylinder, then emits one out word per visit:
// upward requests, the disk end in SCAN mode when the head is below it, then the
// downward requests. A visit from the RAM passes through S_RD, S_CALC and S_OUT, the
// disk end through S_TOP and S_OUT; S_OUT holds while out_ready is low, and the
// out word stays registered and stable. The in channel is not ready while a batch is
// being served. Configuration is written through cfg_we / cfg_index / cfg_data; the
// user must write it only while idle; the block does not enforce it. Reset clears the
// request count and loads start_cylinder 0, a cylinder count of 65536 and SCAN mode.
`default_nettype none

module disk_elevator_scheduler_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire des_pkg::in_word_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output des_pkg::out_word_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [des_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [des_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import des_pkg::*;

  cyl_t                start_cylinder;
  logic [DSIZE_W-1:0]  num_cyls;
  logic                scan_mode;
  logic [DSIZE_W-1:0]  top_full;
  sched_cfg_t          cfg;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  cyl_t                ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  cyl_t                ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cylinder <= '0;
      num_cyls       <= DSIZE_W'(65536);
      scan_mode      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CYLINDER: start_cylinder <= cfg_data[CYL_BITS-1:0];
        CFG_NUM_CYLS:       num_cyls       <= cfg_data[DSIZE_W-1:0];
        CFG_SCAN_MODE:      scan_mode      <= cfg_data[0];
        default:            scan_mode      <= scan_mode;
      endcase
    end
  end

  // The top cylinder saturates at the largest cylinder number; size zero has no top.
  assign top_full           = num_cyls - DSIZE_W'(1);
  assign cfg.start_cylinder = start_cylinder;
  assign cfg.top_cylinder   = (top_full > CYL_MAX) ? CYL_MAX[CYL_BITS-1:0]
                                                   : top_full[CYL_BITS-1:0];
  assign cfg.top_en         = scan_mode && (num_cyls != '0);

  des_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  des_ram #(
    .WIDTH (CYL_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> dv/tb_disk_elevator_scheduler_top.sv
// Self-checking testbench of the disk elevator scheduler: directed and random request batches.
`timescale 1ns / 100ps

module tb_disk_elevator_scheduler_top;
  import des_pkg::*;

  localparam int          RANDOM_ITEMS = 135;
  localparam int          SETTLE       = 80;
  localparam int          HOLD_CYCLES  = 1000;
  localparam longint      TIMEOUT_NS   = 5_000_000;
  localparam int unsigned MOVE_LIMIT   = (1 << MOVE_W) - 1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_CYLINDER;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Scheduler copy: request store and head state as the block should hold them.
  cyl_t         model_store [MAX_REQUESTS];
  int           model_count = 0;
  cyl_t         model_head  = '0;
  move_t        model_moved = '0;
  cyl_t         cfg_start   = '0;
  logic [16:0]  cfg_size    = 17'd65536;
  logic         cfg_scan    = 1'b1;

  out_word_t    visits_due[$];
  cyl_t         last_cyl = '0;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_requests = 0;
  int           holds_taken   = 0;
  int           hold_left     = 0;

  disk_elevator_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t move_to(cyl_t c, logic at_end);
    out_word_t   v;
    int unsigned hop;
    int unsigned sum;
    hop = (c > model_head) ? c - model_head : model_head - c;
    sum = model_moved + hop;
    model_moved = (sum > MOVE_LIMIT) ? move_t'(MOVE_LIMIT) : move_t'(sum);
    model_head = c;
    v = '{visit_cylinder: c, running_movement: model_moved, is_disk_end: at_end,
          final_res: 1'b0};
    return v;
  endfunction

  // Stores one accepted request; the closing word turns the batch into its visit list.
  function automatic void plan_visits(in_word_t w);
    cyl_t        sorted[$];
    out_word_t   trip[$];
    out_word_t   tail;
    int          split;
    logic [16:0] top;
    if (model_count < MAX_REQUESTS) begin
      model_store[model_count] = w.cylinder;
      model_count++;
    end
    if (!w.batch_end) return;
    for (int i = 0; i < model_count; i++) sorted.push_back(model_store[i]);
    model_count = 0;
    sorted.sort();
    model_head  = cfg_start;
    model_moved = '0;
    split = 0;
    while (split < sorted.size() && sorted[split] <= model_head) split++;
    for (int j = split; j < sorted.size(); j++) trip.push_back(move_to(sorted[j], 1'b0));
    top = (cfg_size == 0) ? 17'd0 : cfg_size - 17'd1;
    if (top > CYL_MAX) top = CYL_MAX;
    if (cfg_scan && cfg_size != 0 && 17'(model_head) < top)
      trip.push_back(move_to(cyl_t'(top), 1'b1));
    for (int j = split - 1; j >= 0; j--) trip.push_back(move_to(sorted[j], 1'b0));
    tail = trip.pop_back();
    tail.final_res = 1'b1;
    trip.push_back(tail);
    foreach (trip[i]) visits_due.push_back(trip[i]);
  endfunction

  function automatic cyl_t pick_cylinder();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return cfg_start + cyl_t'($urandom_range(8)) - 16'd4;
      3: return last_cyl;
      4: return (cfg_size == 0) ? cyl_t'($urandom) :
                cyl_t'(cfg_size - 17'd1 - 17'($urandom_range(3)));
      default: return cyl_t'($urandom);
    endcase
  endfunction

  // Valid stays high into the next word when no gap is drawn.
  task automatic send_word(cyl_t cyl, logic last);
    in_word_t w;
    w.cylinder  = cyl;
    w.batch_end = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    last_cyl = cyl;
    plan_visits(w);
  endtask

  task automatic send_batch(int n);
    for (int i = 0; i < n; i++) send_word(pick_cylinder(), i == n - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (visits_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(cyl_t start, logic [16:0] size, logic scan);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_CYLINDER;
    cfg_data  <= CFG_DATA_W'(start);
    @(posedge clk);
    cfg_start = start;
    cfg_index <= CFG_NUM_CYLS;
    cfg_data  <= size;
    @(posedge clk);
    cfg_size = size;
    cfg_index <= CFG_SCAN_MODE;
    cfg_data  <= CFG_DATA_W'(scan);
    @(posedge clk);
    cfg_scan = scan;
    cfg_we <= 1'b0;
  endtask

  task automatic test_default_settings();
    send_word(16'd100, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd40000, 1'b0);
    send_word(16'd100, 1'b1);
    wait_idle();
  endtask

  task automatic test_look_from_top();
    set_config(16'hFFFF, 17'd65536, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'd12345, 1'b1);
    wait_idle();
  endtask

  task automatic test_disk_size_extremes();
    // Zero cylinders: SCAN has no end point to visit.
    set_config(16'd0, 17'd0, 1'b1);
    send_word(16'd7, 1'b0);
    send_word(16'd3, 1'b1);
    wait_idle();
    // Oversized disk: the end point saturates at the top cylinder number.
    set_config(16'd0, 17'h1FFFF, 1'b1);
    send_word(16'd1, 1'b1);
    wait_idle();
    set_config(16'd0, 17'd1, 1'b1);
    send_word(16'd0, 1'b1);
    wait_idle();
    // Requests beyond the last cylinder are still served.
    set_config(16'd10, 17'd100, 1'b1);
    send_word(16'd5000, 1'b0);
    send_word(16'd2, 1'b1);
    wait_idle();
    // Nothing above the head, yet SCAN still travels to the end first.
    set_config(16'd500, 17'd1000, 1'b1);
    send_word(16'd100, 1'b0);
    send_word(16'd500, 1'b1);
    wait_idle();
  endtask

  task automatic test_store_full();
    set_config(16'd1000, 17'd65536, 1'b1);
    send_batch(MAX_REQUESTS + 2);
    wait_idle();
  endtask

  task automatic test_random();
    int          sent;
    int          len;
    cyl_t        start;
    logic [16:0] size;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        if ($urandom_range(2) == 0) begin
          wait_idle();
          case ($urandom_range(3))
            0:       start = '0;
            1:       start = '1;
            default: start = cyl_t'($urandom);
          endcase
          case ($urandom_range(5))
            0:       size = 17'd0;
            1:       size = 17'd1;
            2:       size = 17'd65536;
            3:       size = 17'h1FFFF;
            4:       size = 17'($urandom_range(2, 2000));
            default: size = 17'($urandom);
          endcase
          set_config(start, size, 1'($urandom_range(1)));
        end
        case ($urandom_range(19))
          0:       len = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
          1, 2:    len = $urandom_range(9, MAX_REQUESTS);
          default: len = $urandom_range(1, 8);
        endcase
        send_batch(len);
        sent += len;
      end
    end
    wait_idle();
  endtask

  // The receiver stalls long enough for a second batch to back up at the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_batch(20);
    send_batch(20);
    wait_idle();
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (visits_due.size() == 0) begin
          $display("%0t: unexpected visit word, expected none, ", $time,
                   "actual cyl=%0d move=%0d end=%b final=%b",
                   out_data.visit_cylinder, out_data.running_movement,
                   out_data.is_disk_end, out_data.final_res);
          errors++;
        end else begin
          want = visits_due.pop_front();
          if (out_data !== want) begin
            $display("%0t: visit mismatch, expected cyl=%0d move=%0d end=%b final=%b, ",
                     $time, want.visit_cylinder, want.running_movement,
                     want.is_disk_end, want.final_res,
                     "actual cyl=%0d move=%0d end=%b final=%b",
                     out_data.visit_cylinder, out_data.running_movement,
                     out_data.is_disk_end, out_data.final_res);
            errors++;
          end
        end
      end
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 80;
    test_default_settings();
    test_look_from_top();
    test_disk_size_extremes();
    test_store_full();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
